// ===== hdl/assert_macros.svh =====
// assertion macros shared by the shortest path block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/ddsp_pkg.sv =====
// shared types and constants of the dense shortest path block
`timescale 1ns / 1ps

package ddsp_pkg;

   // default sizes
   localparam int MAX_VERTICES_DEF = 32;
   localparam int WEIGHT_BITS_DEF  = 16;

   // fixed field widths of the ports
   localparam int VERTEX_W    = 5;
   localparam int WEIGHT_IN_W = 16;
   localparam int DIST_OUT_W  = 21;
   localparam int COUNT_W     = 6;

   // vertex count after reset
   localparam logic [COUNT_W-1:0] VCOUNT_RESET = 6'd32;

   // sweep phase selected by the controller
   typedef enum logic [1:0] {
      PH_INIT  = 2'd0,
      PH_SCAN  = 2'd1,
      PH_RELAX = 2'd2,
      PH_EMIT  = 2'd3
   } phase_type;

   // controller to datapath commands
   typedef struct packed {
      logic      load;
      logic      start;
      logic      sweep;
      phase_type phase;
      logic      pick;
      logic      emit_rd;
      logic      emit_ld;
      logic      emit_next;
      logic      fail_ld;
   } ddsp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic req_op;
      logic src_bad;
      logic sweep_done;
      logic found;
      logic rounds_done;
      logic rsp_taken;
      logic rsp_last;
   } ddsp_status_type;

endpackage

// ===== hdl/ddsp_req_if.sv =====
// request channel: weight loads and search starts
`timescale 1ns / 1ps

interface ddsp_req_if
   import ddsp_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   op;
   logic [VERTEX_W-1:0]    row_vertex;
   logic [VERTEX_W-1:0]    col_vertex;
   logic [WEIGHT_IN_W-1:0] weight;
   logic [VERTEX_W-1:0]    source_vertex;

   modport source (
      output valid, op, row_vertex, col_vertex, weight, source_vertex,
      input  ready
   );

   modport sink (
      input  valid, op, row_vertex, col_vertex, weight, source_vertex,
      output ready
   );
endinterface

// ===== hdl/ddsp_rsp_if.sv =====
// response channel: per-vertex distance and predecessor words
`timescale 1ns / 1ps

interface ddsp_rsp_if
   import ddsp_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [VERTEX_W-1:0]   vertex;
   logic [DIST_OUT_W-1:0] distance;
   logic [VERTEX_W-1:0]   predecessor;
   logic                  connected;
   logic                  last;

   modport source (
      output valid, vertex, distance, predecessor, connected, last,
      input  ready
   );

   modport sink (
      input  valid, vertex, distance, predecessor, connected, last,
      output ready
   );
endinterface

// ===== hdl/ddsp_ctrl.sv =====
// controller state machine sequencing init, scan, relax and emit sweeps
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ddsp_ctrl
   import ddsp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ddsp_status_type status,
   output ddsp_cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_INIT      = 9'b000000010,
      ST_SCAN      = 9'b000000100,
      ST_PICK      = 9'b000001000,
      ST_RELAX     = 9'b000010000,
      ST_EMIT_RD   = 9'b000100000,
      ST_EMIT_LD   = 9'b001000000,
      ST_EMIT_WAIT = 9'b010000000,
      ST_FAIL      = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.phase = PH_INIT;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!status.req_op) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = status.src_bad ? ST_FAIL : ST_INIT;
               end
            end
         end
         ST_INIT: begin
            cmd.sweep = 1'b1;
            cmd.phase = PH_INIT;
            if (status.sweep_done) begin
               state_in = status.rounds_done ? ST_EMIT_RD : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.sweep = 1'b1;
            cmd.phase = PH_SCAN;
            if (status.sweep_done) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (status.found) begin
               cmd.pick = 1'b1;
               state_in = ST_RELAX;
            end else begin
               cmd.fail_ld = 1'b1;
               state_in    = ST_EMIT_WAIT;
            end
         end
         ST_RELAX: begin
            cmd.sweep = 1'b1;
            cmd.phase = PH_RELAX;
            if (status.sweep_done) begin
               state_in = status.rounds_done ? ST_EMIT_RD : ST_SCAN;
            end
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            cmd.phase   = PH_EMIT;
            state_in    = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            cmd.emit_ld = 1'b1;
            cmd.phase   = PH_EMIT;
            state_in    = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            cmd.phase = PH_EMIT;
            if (status.rsp_taken) begin
               if (status.rsp_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = ST_EMIT_RD;
               end
            end
         end
         ST_FAIL: begin
            cmd.fail_ld = 1'b1;
            state_in    = ST_EMIT_WAIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_start_to_init, clock, reset, req_valid && req_ready && status.req_op && !status.src_bad, state_ff == ST_INIT)
   `ASSERT_NEXT(a_last_to_idle, clock, reset, state_ff == ST_EMIT_WAIT && status.rsp_taken && status.rsp_last, state_ff == ST_IDLE)
   `ASSERT_NEXT(a_lost_to_fail, clock, reset, state_ff == ST_PICK && !status.found, state_ff == ST_EMIT_WAIT)

endmodule

// ===== hdl/ddsp_dpath.sv =====
// datapath: weight memory, distance tables, selection and relaxation
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ddsp_dpath
   import ddsp_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [COUNT_W-1:0]     csr_write_data,
   input  logic                   req_op,
   input  logic [VERTEX_W-1:0]    req_row_vertex,
   input  logic [VERTEX_W-1:0]    req_col_vertex,
   input  logic [WEIGHT_IN_W-1:0] req_weight,
   input  logic [VERTEX_W-1:0]    req_source_vertex,
   ddsp_rsp_if.source             rsp_ch,
   input  ddsp_cmd_type           cmd,
   output ddsp_status_type        status
);

   localparam int IdxW  = $clog2(MAX_VERTICES);
   localparam int CntW  = $clog2(MAX_VERTICES + 1);
   localparam int AddrW = $clog2(MAX_VERTICES * MAX_VERTICES);
   localparam int DistW = WEIGHT_BITS + IdxW;
   localparam int CandW = DistW + 1;
   localparam int Cells = MAX_VERTICES * MAX_VERTICES;

   // memories
   logic [WEIGHT_BITS-1:0] w_mem    [Cells];
   logic [DistW-1:0]       dist_mem [MAX_VERTICES];
   logic [IdxW-1:0]        pred_mem [MAX_VERTICES];

   // control registers
   logic [COUNT_W-1:0]      vcount_ff;
   logic [CntW-1:0]         n_ff;
   logic [CntW-1:0]         cnt_ff;
   logic [CntW-1:0]         cnt_in;
   logic [CntW-1:0]         round_ff;
   logic                    proc_ff;
   logic                    found_ff;
   logic                    found_in;
   logic [MAX_VERTICES-1:0] visited_ff;
   logic [MAX_VERTICES-1:0] reached_ff;
   logic                    rsp_valid_ff;

   // payload registers
   logic [IdxW-1:0]        src_ff;
   logic [VERTEX_W-1:0]    src5_ff;
   logic [AddrW-1:0]       base_ff;
   logic [IdxW-1:0]        idx_ff;
   logic [DistW-1:0]       best_ff;
   logic [IdxW-1:0]        k_ff;
   logic [WEIGHT_BITS-1:0] w_rd_ff;
   logic [DistW-1:0]       dist_rd_ff;
   logic [IdxW-1:0]        pred_rd_ff;
   logic [VERTEX_W-1:0]    rsp_vertex_ff;
   logic [DIST_OUT_W-1:0]  rsp_distance_ff;
   logic [VERTEX_W-1:0]    rsp_pred_ff;
   logic                   rsp_connected_ff;
   logic                   rsp_last_ff;

   // combinational
   logic [CntW-1:0]        n_act;
   logic                   load_ok;
   logic [AddrW-1:0]       load_addr;
   logic                   issue;
   logic                   proc_now;
   logic [IdxW-1:0]        rd_idx;
   logic [AddrW-1:0]       w_addr;
   logic [CandW-1:0]       cand;
   logic                   sel_hit;
   logic                   relax_hit;
   logic                   dist_we;
   logic [DistW-1:0]       dist_wdata;
   logic [IdxW-1:0]        pred_wdata;
   logic [DIST_OUT_W-1:0]  dist_sat;

   // active vertex count with clamping
   always_comb begin
      if (vcount_ff == '0) begin
         n_act = CntW'(1);
      end else if (int'(vcount_ff) > MAX_VERTICES) begin
         n_act = CntW'(MAX_VERTICES);
      end else begin
         n_act = CntW'(vcount_ff);
      end
   end

   // load address, out of range positions are dropped
   assign load_ok   = (int'(req_row_vertex) < MAX_VERTICES) &&
                      (int'(req_col_vertex) < MAX_VERTICES);
   assign load_addr = AddrW'(int'(req_row_vertex) * MAX_VERTICES + int'(req_col_vertex));

   // sweep read side
   assign issue    = cmd.sweep && (cnt_ff != n_ff);
   assign proc_now = proc_ff && cmd.sweep;
   assign rd_idx   = cnt_ff[IdxW-1:0];
   assign w_addr   = base_ff + AddrW'(rd_idx);

   // selection and relaxation tests on the delayed index
   always_comb begin
      cand      = CandW'(best_ff) + CandW'(w_rd_ff);
      sel_hit   = !visited_ff[idx_ff] && reached_ff[idx_ff] &&
                  (!found_ff || (dist_rd_ff < best_ff));
      relax_hit = (w_rd_ff != '0) && !visited_ff[idx_ff] &&
                  (!reached_ff[idx_ff] || (cand < CandW'(dist_rd_ff)));
   end

   // table write port
   always_comb begin
      dist_we    = 1'b0;
      dist_wdata = DistW'(w_rd_ff);
      pred_wdata = src_ff;
      if (proc_now) begin
         case (cmd.phase)
            PH_INIT: begin
               dist_we    = 1'b1;
               dist_wdata = (idx_ff == src_ff) ? '0 : DistW'(w_rd_ff);
               pred_wdata = src_ff;
            end
            PH_RELAX: begin
               dist_we    = relax_hit;
               dist_wdata = DistW'(cand);
               pred_wdata = k_ff;
            end
            default: begin
               dist_we = 1'b0;
            end
         endcase
      end
   end

   // weight matrix
   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) begin
         w_mem[load_addr] <= WEIGHT_BITS'(req_weight);
      end
      if (issue) begin
         w_rd_ff <= w_mem[w_addr];
      end
   end

   // distance and predecessor tables
   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[idx_ff] <= dist_wdata;
         pred_mem[idx_ff] <= pred_wdata;
      end
      if (issue || cmd.emit_rd) begin
         dist_rd_ff <= dist_mem[rd_idx];
         pred_rd_ff <= pred_mem[rd_idx];
      end
   end

   // sweep counter next value
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.start) begin
         cnt_in = '0;
      end else if (cmd.sweep) begin
         cnt_in = (cnt_ff == n_ff) ? '0 : CntW'(cnt_ff + CntW'(1));
      end else if (cmd.emit_next) begin
         cnt_in = CntW'(cnt_ff + CntW'(1));
      end
   end

   // selection flag next value
   always_comb begin
      found_in = found_ff;
      if (cmd.start || cmd.pick) begin
         found_in = 1'b0;
      end else if (proc_now && (cmd.phase == PH_SCAN) && sel_hit) begin
         found_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= VCOUNT_RESET;
         n_ff         <= CntW'(1);
         cnt_ff       <= '0;
         round_ff     <= CntW'(1);
         proc_ff      <= 1'b0;
         found_ff     <= 1'b0;
         visited_ff   <= '0;
         reached_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            vcount_ff <= csr_write_data;
         end
         cnt_ff   <= cnt_in;
         proc_ff  <= issue;
         found_ff <= found_in;
         if (cmd.start) begin
            n_ff     <= n_act;
            round_ff <= CntW'(1);
         end
         if (cmd.pick) begin
            round_ff        <= CntW'(round_ff + CntW'(1));
            visited_ff[k_ff] <= 1'b1;
         end
         // per-vertex flags from the sweep
         if (proc_now) begin
            if (cmd.phase == PH_INIT) begin
               visited_ff[idx_ff] <= (idx_ff == src_ff);
               reached_ff[idx_ff] <= (idx_ff == src_ff) || (w_rd_ff != '0);
            end else if ((cmd.phase == PH_RELAX) && relax_hit) begin
               reached_ff[idx_ff] <= 1'b1;
            end
         end
         // response handshake
         if (cmd.emit_ld || cmd.fail_ld) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // distance saturation to the port width
   always_comb begin
      if ((DistW > DIST_OUT_W) && ((dist_rd_ff >> DIST_OUT_W) != '0)) begin
         dist_sat = '1;
      end else begin
         dist_sat = DIST_OUT_W'(dist_rd_ff);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= rd_idx;
      if (cmd.start) begin
         src_ff  <= IdxW'(req_source_vertex);
         src5_ff <= req_source_vertex;
         base_ff <= AddrW'(int'(IdxW'(req_source_vertex)) * MAX_VERTICES);
      end
      if (cmd.pick) begin
         base_ff <= AddrW'(int'(k_ff) * MAX_VERTICES);
      end
      if (proc_now && (cmd.phase == PH_SCAN) && sel_hit) begin
         best_ff <= dist_rd_ff;
         k_ff    <= idx_ff;
      end
      if (cmd.emit_ld) begin
         rsp_vertex_ff    <= VERTEX_W'(cnt_ff);
         rsp_distance_ff  <= dist_sat;
         rsp_pred_ff      <= VERTEX_W'(pred_rd_ff);
         rsp_connected_ff <= 1'b1;
         rsp_last_ff      <= (CntW'(cnt_ff + CntW'(1)) == n_ff);
      end else if (cmd.fail_ld) begin
         rsp_vertex_ff    <= src5_ff;
         rsp_distance_ff  <= '0;
         rsp_pred_ff      <= '0;
         rsp_connected_ff <= 1'b0;
         rsp_last_ff      <= 1'b1;
      end
   end

   // response port
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.vertex      = rsp_vertex_ff;
   assign rsp_ch.distance    = rsp_distance_ff;
   assign rsp_ch.predecessor = rsp_pred_ff;
   assign rsp_ch.connected   = rsp_connected_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // status to the controller
   always_comb begin
      status             = '0;
      status.req_op      = req_op;
      status.src_bad     = int'(req_source_vertex) >= int'(n_act);
      status.sweep_done  = (cnt_ff == n_ff);
      status.found       = found_ff;
      status.rounds_done = (round_ff >= n_ff);
      status.rsp_taken   = rsp_valid_ff && rsp_ch.ready;
      status.rsp_last    = rsp_last_ff;
   end

   `ASSERT_IMPLIES(a_load_quiet, clock, reset, cmd.load, !proc_ff && !rsp_valid_ff)
   `ASSERT_IMPLIES(a_relax_visited, clock, reset, cmd.sweep && (cmd.phase == PH_RELAX), visited_ff[k_ff])
   `ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= n_ff)

endmodule

// ===== hdl/dense_dijkstra_shortest_path.sv =====
// top level of the dense single-source shortest path engine
// a load is written when accepted; a start runs an init sweep to fill the tables, then
//   a scan sweep, a pick and a relax sweep in each of n-1 rounds, then one word per
//   vertex or a failure word; sweeps read one entry per cycle, requests wait until done
// reset: synchronous, clears control state and sets vertex_count to 32, matrix not cleared
`timescale 1ns / 1ps

module dense_dijkstra_shortest_path
   import ddsp_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   ddsp_req_if.sink           req_ch,
   ddsp_rsp_if.source         rsp_ch,
   input  logic               csr_write_enable,
   input  logic [COUNT_W-1:0] csr_write_data
);

   ddsp_cmd_type    cmd;
   ddsp_status_type status;

   // sequencing
   ddsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and arithmetic
   ddsp_dpath #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_op            (req_ch.op),
      .req_row_vertex    (req_ch.row_vertex),
      .req_col_vertex    (req_ch.col_vertex),
      .req_weight        (req_ch.weight),
      .req_source_vertex (req_ch.source_vertex),
      .rsp_ch            (rsp_ch),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

// ===== verif/ddsp_checker.sv =====
// op codes of the request word and the checker that predicts and compares shortest path words
`timescale 1ns / 1ps

package ddsp_tb_pkg;

   // request operations
   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SEARCH = 1'b1
   } req_op_type;

endpackage

module ddsp_checker
   import ddsp_pkg::*;
   import ddsp_tb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   ddsp_req_if                req_mon,
   ddsp_rsp_if                rsp_mon,
   input  logic               csr_write_enable,
   input  logic [COUNT_W-1:0] csr_write_data,
   output int                 fail_count,
   output int                 pending_words
);

   localparam int          NV        = MAX_VERTICES_DEF;
   localparam int unsigned DIST_CEIL = (1 << DIST_OUT_W) - 1;

   typedef struct packed {
      logic [VERTEX_W-1:0]   vertex;
      logic [DIST_OUT_W-1:0] distance;
      logic [VERTEX_W-1:0]   predecessor;
      logic                  connected;
      logic                  last;
   } path_word_type;

   // shadow of the weight matrix, the vertex count and the words still owed
   logic [WEIGHT_IN_W-1:0] arc_weight [NV][NV] = '{default: '0};
   logic [COUNT_W-1:0]     vertex_count = VCOUNT_RESET;
   path_word_type          path_words [$];
   int                     mismatches = 0;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns: %s", $time, what);
   endtask

   // vertex count as the block uses it
   function automatic int unsigned vertices_in_use();
      if (vertex_count == 0) return 1;
      if (vertex_count > NV) return NV;
      return 32'(vertex_count);
   endfunction

   task automatic owe_word(input logic [VERTEX_W-1:0] v, input int unsigned total,
                           input logic [VERTEX_W-1:0] pred, input logic conn,
                           input logic fin);
      path_word_type w;
      w.vertex      = v;
      w.distance    = (total > DIST_CEIL) ? DIST_CEIL[DIST_OUT_W-1:0] : total[DIST_OUT_W-1:0];
      w.predecessor = pred;
      w.connected   = conn;
      w.last        = fin;
      path_words.push_back(w);
   endtask

   // single-source search over the shadow matrix, lowest index wins ties
   task automatic predict_search(input logic [VERTEX_W-1:0] src);
      int unsigned         n, k, best, cand;
      int unsigned         path_dist [NV];
      logic [VERTEX_W-1:0] pred [NV];
      bit                  seen [NV];
      bit                  settled [NV];
      bit                  found;
      n = vertices_in_use();
      if (src >= n) begin
         owe_word(src, 0, '0, 1'b0, 1'b1);
         return;
      end
      // first row comes straight from the source, self edge ignored
      for (int i = 0; i < n; i++) begin
         path_dist[i] = 32'(arc_weight[src][i]);
         pred[i]      = src;
         seen[i]      = (arc_weight[src][i] != 0);
         settled[i]   = 1'b0;
      end
      path_dist[src] = 0;
      seen[src]      = 1'b1;
      settled[src]   = 1'b1;
      for (int round = 1; round < n; round++) begin
         found = 1'b0;
         best  = 0;
         k     = 0;
         for (int i = 0; i < n; i++) begin
            if (!settled[i] && seen[i] && (!found || path_dist[i] < best)) begin
               found = 1'b1;
               best  = path_dist[i];
               k     = i;
            end
         end
         // some vertex never reached
         if (!found) begin
            owe_word(src, 0, '0, 1'b0, 1'b1);
            return;
         end
         settled[k] = 1'b1;
         // relax, strict improvements only
         for (int j = 0; j < n; j++) begin
            cand = path_dist[k] + 32'(arc_weight[k][j]);
            if (!settled[j] && arc_weight[k][j] != 0 && (!seen[j] || cand < path_dist[j])) begin
               path_dist[j] = cand;
               seen[j]      = 1'b1;
               pred[j]      = k[VERTEX_W-1:0];
            end
         end
      end
      for (int i = 0; i < n; i++)
         owe_word(i[VERTEX_W-1:0], path_dist[i], pred[i], 1'b1, (i == n - 1));
   endtask

   // watch both channels and the register port
   always @(posedge clock) begin : watch
      path_word_type got, want;
      if (reset) begin
         vertex_count = VCOUNT_RESET;
         path_words.delete();
      end else begin
         if (csr_write_enable) vertex_count = csr_write_data;
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.op == OP_LOAD)
               arc_weight[req_mon.row_vertex][req_mon.col_vertex] = req_mon.weight;
            else
               predict_search(req_mon.source_vertex);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.vertex      = rsp_mon.vertex;
            got.distance    = rsp_mon.distance;
            got.predecessor = rsp_mon.predecessor;
            got.connected   = rsp_mon.connected;
            got.last        = rsp_mon.last;
            if (path_words.size() == 0) begin
               report_mismatch($sformatf("word for vertex %0d with nothing owed", got.vertex));
            end else begin
               want = path_words.pop_front();
               if (got !== want)
                  report_mismatch($sformatf(
                     "word v%0d d%0d p%0d c%0d l%0d, wanted v%0d d%0d p%0d c%0d l%0d",
                     got.vertex, got.distance, got.predecessor, got.connected, got.last,
                     want.vertex, want.distance, want.predecessor, want.connected,
                     want.last));
            end
         end
      end
      pending_words <= path_words.size();
      fail_count    <= mismatches;
   end

endmodule

// ===== verif/testbench.sv =====
// stimulus, clock, reset and verdict for the dense shortest path block
`timescale 1ns / 1ps

module testbench;
   import ddsp_pkg::*;
   import ddsp_tb_pkg::*;

   localparam int NV            = MAX_VERTICES_DEF;
   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 8;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_enable;
   logic [COUNT_W-1:0] csr_write_data;
   int                 fail_count;
   int                 pending_words;
   int                 quiet_cycles = 0;
   int unsigned        active_n = NV;
   bit                 written [NV][NV];
   bit                 calm = 1'b0;

   ddsp_req_if req_ch ();
   ddsp_rsp_if rsp_ch ();

   dense_dijkstra_shortest_path u_top (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   ddsp_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_words    (pending_words)
   );

   always #5 clock = ~clock;

   // result side stalls on about ten percent of cycles, never while calm
   always @(posedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= 10);
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // mostly zero or small weights so ties and detours show up
   function automatic logic [WEIGHT_IN_W-1:0] random_weight();
      case ($urandom_range(9))
         0, 1, 2:    return '0;
         3, 4, 5, 6: return WEIGHT_IN_W'($urandom_range(15, 1));
         7, 8:       return WEIGHT_IN_W'($urandom_range(255, 16));
         default:    return WEIGHT_IN_W'($urandom_range(65535));
      endcase
   endfunction

   function automatic logic [VERTEX_W-1:0] pick_vertex();
      if ($urandom_range(99) < 85) return VERTEX_W'($urandom_range(active_n - 1));
      return VERTEX_W'($urandom_range(NV - 1));
   endfunction

   // one request word, with an occasional gap in front
   task automatic send_word(input req_op_type op, input logic [VERTEX_W-1:0] row,
                            input logic [VERTEX_W-1:0] col,
                            input logic [WEIGHT_IN_W-1:0] w,
                            input logic [VERTEX_W-1:0] src);
      if (!calm && $urandom_range(99) < 10) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.op            <= op;
      req_ch.row_vertex    <= row;
      req_ch.col_vertex    <= col;
      req_ch.weight        <= w;
      req_ch.source_vertex <= src;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic load_weight(input logic [VERTEX_W-1:0] row, input logic [VERTEX_W-1:0] col,
                              input logic [WEIGHT_IN_W-1:0] w);
      send_word(OP_LOAD, row, col, w, VERTEX_W'($urandom_range(NV - 1)));
      written[row][col] = 1'b1;
   endtask

   // every entry a search may read is written first
   task automatic start_search(input logic [VERTEX_W-1:0] src);
      if (src < active_n) begin
         for (int r = 0; r < active_n; r++)
            for (int c = 0; c < active_n; c++)
               if (!written[r][c]) load_weight(VERTEX_W'(r), VERTEX_W'(c), random_weight());
      end
      send_word(OP_SEARCH, VERTEX_W'($urandom_range(NV - 1)), VERTEX_W'($urandom_range(NV - 1)),
                random_weight(), src);
   endtask

   // hold the sender until every owed word is back, then let a load retire
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_vertex_count(input logic [COUNT_W-1:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_n = (v == 0) ? 1 : (v > NV) ? NV : v;
   endtask

   task automatic random_phase(input logic [COUNT_W-1:0] v, input int items, input bit hold);
      set_vertex_count(v);
      for (int i = 0; i < items; i++) begin
         if (hold && i == items / 2) drain();
         if ($urandom_range(99) < 55) load_weight(pick_vertex(), pick_vertex(), random_weight());
         else start_search(pick_vertex());
      end
   endtask

   initial begin
      int unsigned sizes [9] = '{2, 7, 3, 8, 5, 1, 6, 4, 9};
      reset                <= 1'b1;
      csr_write_enable     <= 1'b0;
      csr_write_data       <= '0;
      req_ch.valid         <= 1'b0;
      req_ch.op            <= OP_LOAD;
      req_ch.row_vertex    <= '0;
      req_ch.col_vertex    <= '0;
      req_ch.weight        <= '0;
      req_ch.source_vertex <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // four vertex graph: tie on the pick, equal detour kept out, self edge on the source
      set_vertex_count(4);
      load_weight(0, 0, 5);
      load_weight(0, 1, 2);
      load_weight(0, 2, 2);
      load_weight(0, 3, 0);
      load_weight(1, 0, 0);
      load_weight(1, 1, 0);
      load_weight(1, 2, 0);
      load_weight(1, 3, 3);
      load_weight(2, 0, 0);
      load_weight(2, 1, 0);
      load_weight(2, 2, 0);
      load_weight(2, 3, 3);
      load_weight(3, 0, 1);
      load_weight(3, 1, 0);
      load_weight(3, 2, 16'hFFFF);
      load_weight(3, 3, 0);
      load_weight(31, 31, 16'hFFFF);
      start_search(0);
      start_search(3);
      start_search(1);
      // cut the only exit of vertex 1, then sources past the count
      load_weight(1, 3, 0);
      start_search(1);
      start_search(31);
      start_search(4);
      // count of zero acts as a single vertex
      set_vertex_count(0);
      start_search(0);
      start_search(1);

      // full size and clamped counts: two rows that only point at each other,
      // so a search reads just those two rows before it runs out of vertices
      set_vertex_count(63);
      for (int c = 0; c < NV; c++) begin
         load_weight(VERTEX_W'(5), VERTEX_W'(c), (c == 9) ? 16'd7 : (c == 5) ? 16'd4 : 16'd0);
         load_weight(VERTEX_W'(9), VERTEX_W'(c), (c == 5) ? 16'd3 : 16'd0);
      end
      send_word(OP_SEARCH, '0, '0, '0, VERTEX_W'(5));
      set_vertex_count(40);
      send_word(OP_SEARCH, '0, '0, '0, VERTEX_W'(9));
      set_vertex_count(32);
      send_word(OP_SEARCH, '0, '0, '0, VERTEX_W'(5));

      foreach (sizes[i]) begin
         calm <= (i == 4);
         random_phase(COUNT_W'(sizes[i]), 27, (i == 6));
      end
      calm <= 1'b0;

      drain();
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ddsp_pkg.sv
hdl/ddsp_req_if.sv
hdl/ddsp_rsp_if.sv
hdl/ddsp_ctrl.sv
hdl/ddsp_dpath.sv
hdl/dense_dijkstra_shortest_path.sv
verif/ddsp_checker.sv
verif/testbench.sv
